### design/evlm_pkg.sv
package evlm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 31;
	localparam int TIME_W   = 32;
	localparam int GATE_W   = 2;
	localparam int THR_W    = 16;
	localparam int THR_SQ_W = 32;
	localparam int TMO_W    = 16;
	localparam int LEVEL_W  = 7;
	localparam int LOUD_W   = 2;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RMS_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIMEOUT = 2'd1;

	localparam logic [THR_W-1:0] RMS_THRESHOLD_RST   = 16'd200;
	localparam logic [TMO_W-1:0] SILENCE_TIMEOUT_RST = 16'd1500;

	// gate codes
	localparam logic [GATE_W-1:0] GATE_HOLD  = 2'd0;
	localparam logic [GATE_W-1:0] GATE_CLEAR = 2'd1;
	localparam logic [GATE_W-1:0] GATE_RUN   = 2'd2;

	// loudness classes
	localparam logic [LOUD_W-1:0] LOUD_SILENT = 2'd0;
	localparam logic [LOUD_W-1:0] LOUD_QUIET  = 2'd1;
	localparam logic [LOUD_W-1:0] LOUD_NORMAL = 2'd2;
	localparam logic [LOUD_W-1:0] LOUD_LOUD   = 2'd3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
	localparam logic [LEVEL_W-1:0] BAND_QUIET  = 7'd10;
	localparam logic [LEVEL_W-1:0] BAND_NORMAL = 7'd30;
	localparam logic [LEVEL_W-1:0] BAND_LOUD   = 7'd60;
	// level divisor is 2^LEVEL_SHIFT - 1
	localparam int LEVEL_SHIFT = 15;
	localparam logic [15:0] LEVEL_DIV = 16'd32767;

	typedef struct packed {
		logic              last;
		logic [GATE_W-1:0] gate;
		logic [TIME_W-1:0] time_ms;
	} tag_t;

endpackage

### design/evlm_front.sv
module evlm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [evlm_pkg::SAMPLE_W-1:0] sample,
	input  logic                           block_last,
	input  logic [evlm_pkg::TIME_W-1:0]    time_ms,
	input  logic [evlm_pkg::GATE_W-1:0]    gate,
	output logic                           sq_valid,
	input  logic                           sq_ready,
	output logic [evlm_pkg::SQ_W-1:0]      sq,
	output logic [evlm_pkg::MAG_W-1:0]     mag,
	output evlm_pkg::tag_t                 tag
);
	import evlm_pkg::*;

	logic                v_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	tag_t                tag_s1;
	logic                v_s2;
	logic [SQ_W-1:0]     sq_s2;
	logic [MAG_W-1:0]    mag_s2;
	tag_t                tag_s2;
	logic                rdy_s1;
	logic                rdy_s2;
	logic [MAG_W-1:0]    mag_c;
	logic [2*MAG_W-1:0]  sq_full;

	assign rdy_s2   = !v_s2 || sq_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// magnitude of the most negative sample is 32768, still fits unsigned
	assign mag_c   = sample_s1[SAMPLE_W-1] ? MAG_W'(~sample_s1 + 1'b1) : MAG_W'(sample_s1);
	assign sq_full = mag_c * mag_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			sample_s1      <= sample;
			tag_s1.last    <= block_last;
			tag_s1.gate    <= gate;
			tag_s1.time_ms <= time_ms;
		end
		if (v_s1 && rdy_s2) begin
			sq_s2  <= sq_full[SQ_W-1:0];
			mag_s2 <= mag_c;
			tag_s2 <= tag_s1;
		end
	end

	assign sq_valid = v_s2;
	assign sq       = sq_s2;
	assign mag      = mag_s2;
	assign tag      = tag_s2;

endmodule

### design/evlm_accum.sv
module evlm_accum #(
	parameter int BLOCK_MAX = 256,
	parameter int ENERGY_W  = 31 + $clog2(BLOCK_MAX),
	parameter int CNT_W     = $clog2(BLOCK_MAX + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sq_valid,
	output logic                       sq_ready,
	input  logic [evlm_pkg::SQ_W-1:0]  sq,
	input  logic [evlm_pkg::MAG_W-1:0] mag,
	input  evlm_pkg::tag_t             tag,
	output logic                       blk_valid,
	input  logic                       blk_ready,
	output logic [ENERGY_W-1:0]        blk_energy,
	output logic [evlm_pkg::MAG_W-1:0] blk_peak,
	output logic [CNT_W-1:0]           blk_count,
	output evlm_pkg::tag_t             blk_tag
);
	import evlm_pkg::*;

	logic [ENERGY_W-1:0] energy_q;
	logic [MAG_W-1:0]    peak_q;
	logic [CNT_W-1:0]    count_q;
	logic                v_s3;
	logic [ENERGY_W-1:0] energy_s3;
	logic [MAG_W-1:0]    peak_s3;
	logic [CNT_W-1:0]    count_s3;
	tag_t                tag_s3;
	logic                take;
	logic                counted;
	logic [ENERGY_W-1:0] energy_c;
	logic [MAG_W-1:0]    peak_c;
	logic [CNT_W-1:0]    count_c;

	// a block end needs room in the block register; other items always go in
	assign sq_ready = !tag.last || !v_s3 || blk_ready;
	assign take     = sq_valid && sq_ready;

	// drop samples past the block limit
	assign counted  = count_q < CNT_W'(BLOCK_MAX);
	assign energy_c = counted ? energy_q + ENERGY_W'(sq) : energy_q;
	assign peak_c   = (counted && (mag > peak_q)) ? mag : peak_q;
	assign count_c  = counted ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			peak_q   <= '0;
			count_q  <= '0;
			v_s3     <= 1'b0;
		end else begin
			if (take) begin
				if (tag.last) begin
					energy_q <= '0;
					peak_q   <= '0;
					count_q  <= '0;
				end else begin
					energy_q <= energy_c;
					peak_q   <= peak_c;
					count_q  <= count_c;
				end
			end
			if (!v_s3 || blk_ready) begin
				v_s3 <= take && tag.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tag.last) begin
			energy_s3 <= energy_c;
			peak_s3   <= peak_c;
			count_s3  <= count_c;
			tag_s3    <= tag;
		end
	end

	assign blk_valid  = v_s3;
	assign blk_energy = energy_s3;
	assign blk_peak   = peak_s3;
	assign blk_count  = count_s3;
	assign blk_tag    = tag_s3;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_MAX))
		else $error("sample count ran past the block limit");
`endif

endmodule

### design/evlm_decide.sv
module evlm_decide #(
	parameter int BLOCK_MAX = 256,
	parameter int ENERGY_W  = 31 + $clog2(BLOCK_MAX),
	parameter int CNT_W     = $clog2(BLOCK_MAX + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [evlm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [evlm_pkg::THR_W-1:0]     cfg_data,
	input  logic                           blk_valid,
	output logic                           blk_ready,
	input  logic [ENERGY_W-1:0]            blk_energy,
	input  logic [evlm_pkg::MAG_W-1:0]     blk_peak,
	input  logic [CNT_W-1:0]               blk_count,
	input  evlm_pkg::tag_t                 blk_tag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [evlm_pkg::MAG_W-1:0]     peak_magnitude,
	output logic [evlm_pkg::LEVEL_W-1:0]   level,
	output logic [evlm_pkg::LOUD_W-1:0]    loudness,
	output logic                           speaking,
	output logic                           stop_request
);
	import evlm_pkg::*;

	localparam int PROD_W = THR_SQ_W + CNT_W;
	localparam int LVX_W  = MAG_W + LEVEL_W;
	localparam int Q_W    = LVX_W - LEVEL_SHIFT;

	logic [THR_SQ_W-1:0] thr_sq_q;
	logic [TMO_W-1:0]    timeout_q;
	logic                speaking_q;
	logic                timing_q;
	logic [TIME_W-1:0]   start_q;

	logic                v_s4;
	logic [PROD_W-1:0]   prod_s4;
	logic [ENERGY_W-1:0] energy_s4;
	logic [MAG_W-1:0]    peak_s4;
	logic [LEVEL_W-1:0]  level_s4;
	logic [LOUD_W-1:0]   loud_s4;
	tag_t                tag_s4;

	logic                out_valid_q;
	logic [MAG_W-1:0]    peak_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [LOUD_W-1:0]   loud_q;
	logic                speak_out_q;
	logic                stop_q;

	logic                rdy_out;
	logic                rdy_s4;
	logic [2*THR_W-1:0]  thr_sq_c;
	logic [LVX_W-1:0]    lvx;
	logic [Q_W-1:0]      q0;
	logic [15:0]         rem;
	logic [Q_W-1:0]      quo;
	logic [LEVEL_W-1:0]  level_c;
	logic [LOUD_W-1:0]   loud_c;
	logic                speech;
	logic [TIME_W-1:0]   elapsed;
	logic                speak_n;
	logic                timing_n;
	logic [TIME_W-1:0]   start_n;
	logic                stop_n;

	assign cfg_ready = 1'b1;
	assign thr_sq_c  = cfg_data * cfg_data;

	assign rdy_out   = !out_valid_q || out_ready;
	assign rdy_s4    = !v_s4 || rdy_out;
	assign blk_ready = rdy_s4;

	// floor(peak*100/32767): divide by 2^15, then one correction step
	assign lvx  = LVX_W'(blk_peak) * LVX_W'(LEVEL_FULL);
	assign q0   = lvx[LVX_W-1:LEVEL_SHIFT];
	assign rem  = 16'(lvx[LEVEL_SHIFT-1:0]) + 16'(q0);
	assign quo  = (rem >= LEVEL_DIV) ? q0 + 1'b1 : q0;
	assign level_c = (quo > Q_W'(LEVEL_FULL)) ? LEVEL_FULL : quo[LEVEL_W-1:0];

	always_comb begin
		loud_c = LOUD_SILENT;
		if (level_c > BAND_QUIET) begin
			loud_c = LOUD_QUIET;
		end
		if (level_c > BAND_NORMAL) begin
			loud_c = LOUD_NORMAL;
		end
		if (level_c > BAND_LOUD) begin
			loud_c = LOUD_LOUD;
		end
	end

	// rms >= threshold  <=>  sum of squares >= threshold^2 * count
	assign speech  = PROD_W'(energy_s4) >= prod_s4;
	assign elapsed = tag_s4.time_ms - start_q;

	always_comb begin
		speak_n  = speaking_q;
		timing_n = timing_q;
		start_n  = start_q;
		stop_n   = 1'b0;
		case (tag_s4.gate)
			GATE_CLEAR: begin
				speak_n  = 1'b0;
				timing_n = 1'b0;
				start_n  = '0;
			end
			GATE_RUN: begin
				if (speech) begin
					speak_n  = 1'b1;
					timing_n = 1'b0;
					start_n  = '0;
				end else if (speaking_q) begin
					if (!timing_q) begin
						// first silent block only starts the timer
						timing_n = 1'b1;
						start_n  = tag_s4.time_ms;
					end else if (elapsed >= TIME_W'(timeout_q)) begin
						stop_n   = 1'b1;
						speak_n  = 1'b0;
						timing_n = 1'b0;
						start_n  = '0;
					end
				end
			end
			default: begin
				// hold, and the unused code acts as hold
				speak_n  = speaking_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q    <= THR_SQ_W'(RMS_THRESHOLD_RST * RMS_THRESHOLD_RST);
			timeout_q   <= SILENCE_TIMEOUT_RST;
			speaking_q  <= 1'b0;
			timing_q    <= 1'b0;
			start_q     <= '0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_RMS_THRESHOLD:   thr_sq_q  <= thr_sq_c;
					REG_SILENCE_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (rdy_s4) begin
				v_s4 <= blk_valid;
			end
			if (rdy_out) begin
				out_valid_q <= v_s4;
			end
			if (v_s4 && rdy_out) begin
				speaking_q <= speak_n;
				timing_q   <= timing_n;
				start_q    <= start_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_valid && rdy_s4) begin
			prod_s4   <= PROD_W'(thr_sq_q) * PROD_W'(blk_count);
			energy_s4 <= blk_energy;
			peak_s4   <= blk_peak;
			level_s4  <= level_c;
			loud_s4   <= loud_c;
			tag_s4    <= blk_tag;
		end
		if (v_s4 && rdy_out) begin
			peak_q      <= peak_s4;
			level_q     <= level_s4;
			loud_q      <= loud_s4;
			speak_out_q <= speak_n;
			stop_q      <= stop_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_magnitude = peak_q;
	assign level          = level_q;
	assign loudness       = loud_q;
	assign speaking       = speak_out_q;
	assign stop_request   = stop_q;

`ifndef SYNTHESIS
	a_timing_needs_speech: assert property (@(posedge clk) disable iff (!arst_n)
		timing_q |-> speaking_q)
		else $error("silence timer running without speech");
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stop_q) |-> (!speak_out_q && !speaking_q && !timing_q))
		else $error("stop request left VAD state set");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_q <= LEVEL_FULL))
		else $error("level above full scale");
`endif

endmodule

### design/energy_vad_level_meter_core.sv
// A block-end result passes the s1, s2, s3, s4 and output registers before out_valid.
// Throughput: one item per cycle; the square, accumulate, threshold-product and VAD
// stages are each one register apart, and a waiting result does not stop intake
// until every stage ahead of it is full.
// Reset: arst_n clears all accumulators, VAD state and valid flags and loads the
// register defaults (threshold 200, timeout 1500 ms); no clearing pass is needed.
module energy_vad_level_meter_core #(
	parameter int BLOCK_MAX = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [evlm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [evlm_pkg::THR_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [evlm_pkg::SAMPLE_W-1:0] sample,
	input  logic                             block_last,
	input  logic [evlm_pkg::TIME_W-1:0]      time_ms,
	input  logic [evlm_pkg::GATE_W-1:0]      gate,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [evlm_pkg::MAG_W-1:0]       peak_magnitude,
	output logic [evlm_pkg::LEVEL_W-1:0]     level,
	output logic [evlm_pkg::LOUD_W-1:0]      loudness,
	output logic                             speaking,
	output logic                             stop_request
);
	import evlm_pkg::*;

	localparam int ENERGY_W = 31 + $clog2(BLOCK_MAX);
	localparam int CNT_W    = $clog2(BLOCK_MAX + 1);

	logic                sq_valid;
	logic                sq_ready;
	logic [SQ_W-1:0]     sq;
	logic [MAG_W-1:0]    mag;
	tag_t                sq_tag;
	logic                blk_valid;
	logic                blk_ready;
	logic [ENERGY_W-1:0] blk_energy;
	logic [MAG_W-1:0]    blk_peak;
	logic [CNT_W-1:0]    blk_count;
	tag_t                blk_tag;

	evlm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.block_last (block_last),
		.time_ms    (time_ms),
		.gate       (gate),
		.sq_valid   (sq_valid),
		.sq_ready   (sq_ready),
		.sq         (sq),
		.mag        (mag),
		.tag        (sq_tag)
	);

	evlm_accum #(
		.BLOCK_MAX (BLOCK_MAX),
		.ENERGY_W  (ENERGY_W),
		.CNT_W     (CNT_W)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.sq_valid   (sq_valid),
		.sq_ready   (sq_ready),
		.sq         (sq),
		.mag        (mag),
		.tag        (sq_tag),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.blk_energy (blk_energy),
		.blk_peak   (blk_peak),
		.blk_count  (blk_count),
		.blk_tag    (blk_tag)
	);

	evlm_decide #(
		.BLOCK_MAX (BLOCK_MAX),
		.ENERGY_W  (ENERGY_W),
		.CNT_W     (CNT_W)
	) u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.blk_valid      (blk_valid),
		.blk_ready      (blk_ready),
		.blk_energy     (blk_energy),
		.blk_peak       (blk_peak),
		.blk_count      (blk_count),
		.blk_tag        (blk_tag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.peak_magnitude (peak_magnitude),
		.level          (level),
		.loudness       (loudness),
		.speaking       (speaking),
		.stop_request   (stop_request)
	);

endmodule

### verif/energy_vad_level_meter_core_tb.sv
module energy_vad_level_meter_core_tb;
	import evlm_pkg::*;

	localparam int BLOCK_LEN_MAX = 256;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLDOFF_CYCLES = 300;

	// gate code with no function of its own, and register slots with no register
	localparam logic [GATE_W-1:0] GATE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic                blk_end;
		logic [TIME_W-1:0]   t_ms;
		logic [GATE_W-1:0]   gate;
	} audio_item_t;

	typedef struct packed {
		logic [MAG_W-1:0]   peak;
		logic [LEVEL_W-1:0] level;
		logic [LOUD_W-1:0]  loudness;
		logic               speaking;
		logic               stop;
	} meter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic block_last = 1'b0;
	logic [TIME_W-1:0] time_ms = '0;
	logic [GATE_W-1:0] gate = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [MAG_W-1:0] peak_magnitude;
	logic [LEVEL_W-1:0] level;
	logic [LOUD_W-1:0] loudness;
	logic speaking;
	logic stop_request;

	energy_vad_level_meter_core #(
		.BLOCK_MAX(BLOCK_LEN_MAX)
	) DUT (.*);

	always #6 clk = ~clk;

	// stimulus knobs, changed by the sequence just after rising edges only
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_on = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	audio_item_t sample_q[$];
	meter_result_t result_q[$];
	audio_item_t next_item;
	meter_result_t predicted;
	meter_result_t oldest;

	// block accumulators, VAD state and registers as the block should hold them
	logic [38:0] blk_energy = '0;
	logic [MAG_W-1:0] blk_peak = '0;
	logic [8:0] blk_count = '0;
	logic vad_speaking = 1'b0;
	logic vad_timing = 1'b0;
	logic [TIME_W-1:0] vad_start = '0;
	logic [THR_W-1:0] thr_q = RMS_THRESHOLD_RST;
	logic [TMO_W-1:0] tmo_q = SILENCE_TIMEOUT_RST;

	int err_cnt = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int speaking_seen = 0;
	int stops_seen = 0;
	int dropped_cnt = 0;
	int holdoff_cnt = 0;
	bit holdoff_used = 1'b0;

	function automatic void vad_idle();
		vad_speaking = 1'b0;
		vad_timing = 1'b0;
		vad_start = '0;
	endfunction

	// absorb one sample; on a block end produce the block result and restart the block
	function automatic bit meter_step(input logic [SAMPLE_W-1:0] smp, input logic blk_end,
			input logic [TIME_W-1:0] now, input logic [GATE_W-1:0] gt,
			output meter_result_t r);
		logic [MAG_W-1:0] mag;
		logic [31:0] pct;
		logic halt;
		r = '0;
		halt = 1'b0;
		mag = smp[SAMPLE_W-1] ? MAG_W'(~smp + 16'd1) : smp;
		if (blk_count < BLOCK_LEN_MAX) begin
			if (mag > blk_peak)
				blk_peak = mag;
			blk_energy = blk_energy + 39'(mag) * 39'(mag);
			blk_count = blk_count + 9'd1;
		end else begin
			dropped_cnt++;
		end
		if (!blk_end)
			return 1'b0;
		case (gt)
		GATE_CLEAR: vad_idle();
		GATE_RUN: begin
			if (64'(blk_energy) >= 64'(thr_q) * 64'(thr_q) * 64'(blk_count)) begin
				vad_speaking = 1'b1;
				vad_timing = 1'b0;
				vad_start = '0;
			end else if (vad_speaking) begin
				if (!vad_timing) begin
					vad_timing = 1'b1;
					vad_start = now;
				end else if (TIME_W'(now - vad_start) >= TIME_W'(tmo_q)) begin
					halt = 1'b1;
					vad_idle();
				end
			end
		end
		default: ; // hold, and the unused code acts as hold
		endcase
		pct = (32'(blk_peak) * 32'(LEVEL_FULL)) / 32'(LEVEL_DIV);
		if (pct > 32'(LEVEL_FULL))
			pct = 32'(LEVEL_FULL);
		r.peak = blk_peak;
		r.level = pct[LEVEL_W-1:0];
		r.loudness = LOUD_SILENT;
		if (r.level > BAND_QUIET)
			r.loudness = LOUD_QUIET;
		if (r.level > BAND_NORMAL)
			r.loudness = LOUD_NORMAL;
		if (r.level > BAND_LOUD)
			r.loudness = LOUD_LOUD;
		r.speaking = vad_speaking;
		r.stop = halt;
		blk_energy = '0;
		blk_peak = '0;
		blk_count = '0;
		return 1'b1;
	endfunction

	// sample sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			block_last <= 1'b0;
			time_ms <= '0;
			gate <= GATE_HOLD;
		end else if (!in_valid || in_ready) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = sample_q.pop_front();
				in_valid <= 1'b1;
				sample <= next_item.smp;
				block_last <= next_item.blk_end;
				time_ms <= next_item.t_ms;
				gate <= next_item.gate;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver; one long hold-off when the pressure phase begins
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			holdoff_cnt <= 0;
			holdoff_used <= 1'b0;
		end else if (pressure_on && !holdoff_used) begin
			holdoff_used <= 1'b1;
			holdoff_cnt <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (holdoff_cnt != 0) begin
			holdoff_cnt <= holdoff_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// predict on every accepted item, compare every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_RMS_THRESHOLD:   thr_q = cfg_data;
				REG_SILENCE_TIMEOUT: tmo_q = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				samples_sent++;
				if (meter_step(sample, block_last, time_ms, gate, predicted))
					result_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result item: peak_magnitude %0d", peak_magnitude);
					err_cnt++;
				end else begin
					oldest = result_q.pop_front();
					results_seen++;
					if (oldest.speaking)
						speaking_seen++;
					if (oldest.stop)
						stops_seen++;
					if (peak_magnitude !== oldest.peak) begin
						$error("peak_magnitude: expected %0d, got %0d", oldest.peak,
							peak_magnitude);
						err_cnt++;
					end
					if (level !== oldest.level) begin
						$error("level: expected %0d, got %0d", oldest.level, level);
						err_cnt++;
					end
					if (loudness !== oldest.loudness) begin
						$error("loudness: expected %0d, got %0d", oldest.loudness, loudness);
						err_cnt++;
					end
					if (speaking !== oldest.speaking) begin
						$error("speaking: expected %0d, got %0d", oldest.speaking, speaking);
						err_cnt++;
					end
					if (stop_request !== oldest.stop) begin
						$error("stop_request: expected %0d, got %0d", oldest.stop,
							stop_request);
						err_cnt++;
					end
				end
			end
		end
	end

	function automatic void push_item(logic [SAMPLE_W-1:0] s, logic e, logic [TIME_W-1:0] t,
			logic [GATE_W-1:0] g);
		sample_q.push_back('{smp: s, blk_end: e, t_ms: t, gate: g});
	endfunction

	// random blocks: loud, quiet, right at the threshold, or pinned at full scale
	task automatic add_blocks(int n, int min_len, int max_len);
		int len;
		int kind;
		int m;
		int pick;
		logic [SAMPLE_W-1:0] s;
		logic [MAG_W-1:0] mag;
		logic [GATE_W-1:0] g;
		for (int b = 0; b < n; b++) begin
			len = $urandom_range(min_len, max_len);
			kind = $urandom_range(99);
			for (int i = 0; i < len; i++) begin
				if (kind < 35) begin
					s = SAMPLE_W'($urandom);
				end else if (kind >= 90) begin
					s = (kind < 95) ? 16'h8000 : 16'h7FFF;
				end else begin
					if (kind < 70)
						m = $urandom_range(0, 40);
					else
						m = int'(thr_q) + $urandom_range(0, 2) - 1;
					if (m < 0)
						m = 0;
					if (m > 32768)
						m = 32768;
					mag = MAG_W'(m);
					s = $urandom_range(1) ? SAMPLE_W'(~mag + 16'd1) : mag;
				end
				if (i != len - 1) begin
					push_item(s, 1'b0, $urandom, GATE_W'($urandom_range(3)));
				end else begin
					pick = $urandom_range(99);
					if (pick < 70)
						clock_ms += $urandom_range(0, 1200);
					else if (pick < 90)
						clock_ms += $urandom_range(0, 70000);
					else
						clock_ms = $urandom;
					pick = $urandom_range(99);
					if (pick < 75)
						g = GATE_RUN;
					else if (pick < 85)
						g = GATE_HOLD;
					else if (pick < 92)
						g = GATE_CLEAR;
					else
						g = GATE_UNUSED;
					push_item(s, 1'b1, clock_ms, g);
				end
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// hold until every queued item went in and every result came out
	task automatic settle();
		do @(negedge clk); while (sample_q.size() != 0 || in_valid || result_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int band_mags[6];
		band_mags = '{3604, 3605, 10157, 10158, 19987, 19988};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed blocks at the reset register values
		push_item(16'h0000, 1'b1, 32'd0, GATE_RUN);
		push_item(16'h8000, 1'b1, 32'd10, GATE_RUN);
		push_item(16'h7FFF, 1'b1, 32'd20, GATE_HOLD);
		push_item(16'h0001, 1'b0, $urandom, GATE_RUN);
		push_item(16'hFFFF, 1'b0, $urandom, GATE_HOLD);
		push_item(16'h0000, 1'b1, 32'd30, GATE_CLEAR);
		foreach (band_mags[i])
			push_item(SAMPLE_W'(band_mags[i]), 1'b1, 32'd40, GATE_RUN);
		// silence after speech: timer starts, one short of timeout, hold, then stop
		push_item(16'h0000, 1'b1, 32'd1000, GATE_RUN);
		push_item(16'h0000, 1'b1, 32'd2499, GATE_RUN);
		push_item(16'h0000, 1'b1, 32'd2500, GATE_UNUSED);
		push_item(16'h0000, 1'b1, 32'd2500, GATE_RUN);
		// timeout reached exactly across the timestamp wrap
		push_item(16'h4000, 1'b1, 32'd5000, GATE_RUN);
		push_item(16'h0000, 1'b1, 32'hFFFF_FF00, GATE_RUN);
		push_item(16'h0000, 1'b1, 32'h0000_04DC, GATE_RUN);
		// energy exactly at the threshold, then just under it
		push_item(16'd200, 1'b0, $urandom, GATE_CLEAR);
		push_item(-16'sd200, 1'b1, 32'd6000, GATE_RUN);
		push_item(16'd199, 1'b1, 32'd6100, GATE_RUN);
		settle();

		write_reg(REG_RMS_THRESHOLD, THR_W'($urandom_range(100, 1500)));
		write_reg(REG_SILENCE_TIMEOUT, TMO_W'($urandom_range(200, 3000)));
		clock_ms = 32'hFFFF_F000;
		add_blocks(12, 1, 6);
		settle();

		write_reg(REG_RMS_THRESHOLD, '0);
		write_reg(REG_SILENCE_TIMEOUT, '0);
		send_idle_pct = 61;
		add_blocks(12, 1, 6);
		settle();

		write_reg(REG_RMS_THRESHOLD, 16'd32768);
		write_reg(REG_SILENCE_TIMEOUT, 16'hFFFF);
		write_reg(REG_UNMAPPED_LO, THR_W'($urandom));
		write_reg(REG_UNMAPPED_HI, THR_W'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 61;
		add_blocks(4, 1, 6);
		add_blocks(1, BLOCK_LEN_MAX + 1, BLOCK_LEN_MAX + 6);
		add_blocks(4, 1, 6);
		settle();

		write_reg(REG_RMS_THRESHOLD, THR_W'($urandom_range(1, 32767)));
		write_reg(REG_SILENCE_TIMEOUT, TMO_W'($urandom_range(0, 65535)));
		send_idle_pct = 23;
		recv_stall_pct = 23;
		add_blocks(12, 1, 6);
		settle();

		// receiver holds off while short blocks pile up behind it
		write_reg(REG_RMS_THRESHOLD, 16'd300);
		write_reg(REG_SILENCE_TIMEOUT, 16'd500);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_on = 1'b1;
		add_blocks(60, 1, 2);
		settle();

		$display("tb: %0d samples in, %0d block results compared, %0d speaking, %0d stops",
			samples_sent, results_seen, speaking_seen, stops_seen);
		$display("tb: thresholds 0..32768, timeouts 0..65535, %0d samples past block limit",
			dropped_cnt);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(12 * 500000);
		$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
design/evlm_pkg.sv
design/evlm_front.sv
design/evlm_accum.sv
design/evlm_decide.sv
design/energy_vad_level_meter_core.sv
verif/energy_vad_level_meter_core_tb.sv
